### sv/cpid_pkg.sv
// shared types and constants of the cascaded pid axis controller
`default_nettype none
package cpid_pkg;

	localparam int GAIN_W  = 48;
	localparam int VALUE_W = 48;
	localparam int INTEG_W = 64;
	localparam int ACC_W   = 128;
	localparam int DT_W    = 16;
	localparam int QUO_W   = 49;

	localparam logic [GAIN_W-1:0] KP_RESET = 48'd56294995342131;
	localparam logic [GAIN_W-1:0] KI_RESET = 48'd703687;
	localparam logic [GAIN_W-1:0] KD_RESET = 48'd351844;

	typedef enum logic [1:0] {
		REG_KP   = 2'd0,
		REG_KI   = 2'd1,
		REG_KD   = 2'd2,
		REG_SIGN = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                      start;
		logic                      clr;
		logic [GAIN_W-1:0]         gain;
		logic signed [INTEG_W-1:0] val;
	} mul_cmd_t;

	typedef struct packed {
		logic                    start;
		logic signed [QUO_W-1:0] dividend;
		logic [DT_W-1:0]         divisor;
	} div_cmd_t;

endpackage
`default_nettype wire

### sv/cascaded_pid_axis_controller_unit.sv
// top level: two series pid stages on one shared multiplier and divider
//
// channel   direction  tdata fields (low bit up)
// s_axis    in         reference_position[7:0], measured_position[15:8],
//                      elapsed_ms[31:16]
// m_axis    out        move_steps[31:0]
// cfg       in         index 0 prop_gain, 1 integral_gain, 2 derivative_gain,
//                      3 error_sign
//
// no transaction is taken until the update of the last one is through; in each
// stage the serial divide for the derivative runs beside the dt product, the
// integral and the first two gain products, and the derivative product follows
// once it finishes
// reset clears the integrals, the previous errors and restores the gains
// the finished result waits in an output register; the next transaction is
// taken while it waits, and the final step only stalls while that register is full
`default_nettype none
module cascaded_pid_axis_controller_unit #(
	parameter int GAIN_FRACTION_BITS  = 46,
	parameter int VALUE_FRACTION_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // reference_position, measured_position, elapsed_ms
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,  // move_steps
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [47:0] cfg_data
);
	import cpid_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PROD, ST_MWAIT, ST_INTEG, ST_KP, ST_KI,
		ST_DWAIT, ST_KD, ST_SHIFT, ST_FINAL
	} state_t;

	// config registers
	logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic              sign_q;

	// sequencer
	state_t state_q, ret_q;
	logic   stage_q;

	// per-stage state
	logic signed [INTEG_W-1:0] integ_q [2];
	logic signed [VALUE_W-1:0] prev_q  [2];

	// working values
	logic signed [VALUE_W-1:0] e_q, o2_q;
	logic [DT_W-1:0]           dt_q;
	logic                      out_valid_q;
	logic [31:0]               out_data_q;

	mul_cmd_t                  mul_cmd;
	div_cmd_t                  div_cmd;
	logic                      mul_busy, mul_done, div_busy;
	logic [ACC_W-1:0]          acc;
	logic signed [QUO_W-1:0]   quo;

	logic                      accept;
	logic signed [8:0]         diff;
	logic signed [INTEG_W:0]   isum;
	logic signed [INTEG_W-1:0] integ_next;
	logic signed [ACC_W-1:0]   shifted;
	logic signed [VALUE_W-1:0] stage_out;
	logic signed [VALUE_W-1:0] mv_floor, mv_trunc;
	logic [31:0]               mv_sat;
	logic                      out_free;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// error term from the input bytes
	assign diff = sign_q ? ({1'b0, s_axis_tdata[15:8]} - {1'b0, s_axis_tdata[7:0]})
	                     : ({1'b0, s_axis_tdata[7:0]} - {1'b0, s_axis_tdata[15:8]});

	// integral with clamp at the signed 64-bit limits
	assign isum = {integ_q[stage_q][INTEG_W-1], integ_q[stage_q]}
	            + {acc[INTEG_W-1], acc[INTEG_W-1:0]};
	assign integ_next = (isum[INTEG_W] != isum[INTEG_W-1])
	                  ? {isum[INTEG_W], {(INTEG_W-1){~isum[INTEG_W]}}}
	                  : isum[INTEG_W-1:0];

	// drop gain fraction (floor), clamp to 48 bits
	assign shifted = $signed(acc) >>> GAIN_FRACTION_BITS;
	assign stage_out = (shifted[ACC_W-1:VALUE_W-1] != {(ACC_W-VALUE_W+1){1'b0}} &&
	                    shifted[ACC_W-1:VALUE_W-1] != {(ACC_W-VALUE_W+1){1'b1}})
	                 ? {shifted[ACC_W-1], {(VALUE_W-1){~shifted[ACC_W-1]}}}
	                 : shifted[VALUE_W-1:0];

	// whole steps, truncated toward zero, clamped to 32 bits
	assign mv_floor = o2_q >>> VALUE_FRACTION_BITS;
	assign mv_trunc = (o2_q[VALUE_W-1] && (o2_q[VALUE_FRACTION_BITS-1:0] != '0))
	                ? mv_floor + 48'sd1 : mv_floor;
	assign mv_sat = (mv_trunc[VALUE_W-1:31] != {(VALUE_W-31){1'b0}} &&
	                 mv_trunc[VALUE_W-1:31] != {(VALUE_W-31){1'b1}})
	              ? {mv_trunc[VALUE_W-1], {31{~mv_trunc[VALUE_W-1]}}}
	              : mv_trunc[31:0];

	// commands to the shared units
	always_comb begin
		mul_cmd       = '0;
		div_cmd       = '0;
		div_cmd.dividend = {e_q[VALUE_W-1], e_q} - {prev_q[stage_q][VALUE_W-1], prev_q[stage_q]};
		div_cmd.divisor  = dt_q;
		unique case (state_q)
			ST_PROD: begin
				mul_cmd.start = 1'b1;
				mul_cmd.clr   = 1'b1;
				mul_cmd.gain  = {32'b0, dt_q};
				mul_cmd.val   = INTEG_W'(e_q);
				div_cmd.start = 1'b1;
			end
			ST_KP: begin
				mul_cmd.start = 1'b1;
				mul_cmd.clr   = 1'b1;
				mul_cmd.gain  = kp_q;
				mul_cmd.val   = INTEG_W'(e_q);
			end
			ST_KI: begin
				mul_cmd.start = 1'b1;
				mul_cmd.gain  = ki_q;
				mul_cmd.val   = integ_q[stage_q];
			end
			ST_KD: begin
				mul_cmd.start = 1'b1;
				mul_cmd.gain  = kd_q;
				mul_cmd.val   = INTEG_W'(quo);
			end
			default: begin
			end
		endcase
	end

	cpid_mul_unit u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.busy   (mul_busy),
		.done   (mul_done),
		.acc    (acc)
	);

	cpid_div_unit u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.busy     (div_busy),
		.quotient (quo)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= KP_RESET;
			ki_q   <= KI_RESET;
			kd_q   <= KD_RESET;
			sign_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KP:   kp_q   <= cfg_data;
				REG_KI:   ki_q   <= cfg_data;
				REG_KD:   kd_q   <= cfg_data;
				REG_SIGN: sign_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	// sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			stage_q     <= 1'b0;
			integ_q[0]  <= '0;
			integ_q[1]  <= '0;
			prev_q[0]   <= '0;
			prev_q[1]   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished move, else drop the one just taken
			if (state_q == ST_FINAL && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stage_q <= 1'b0;
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					ret_q   <= ST_INTEG;
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mul_done) begin
						state_q <= ret_q;
					end
				end
				ST_INTEG: begin
					integ_q[stage_q] <= integ_next;
					state_q          <= ST_KP;
				end
				ST_KP: begin
					ret_q   <= ST_KI;
					state_q <= ST_MWAIT;
				end
				ST_KI: begin
					ret_q   <= ST_DWAIT;
					state_q <= ST_MWAIT;
				end
				ST_DWAIT: begin
					if (!div_busy) begin
						state_q <= ST_KD;
					end
				end
				ST_KD: begin
					ret_q   <= ST_SHIFT;
					state_q <= ST_MWAIT;
				end
				ST_SHIFT: begin
					prev_q[stage_q] <= e_q;
					if (!stage_q) begin
						stage_q <= 1'b1;
						state_q <= ST_PROD;
					end else begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			e_q  <= VALUE_W'(diff) <<< VALUE_FRACTION_BITS;
			dt_q <= (s_axis_tdata[31:16] == '0) ? 16'd1 : s_axis_tdata[31:16];
		end
		if (state_q == ST_SHIFT) begin
			e_q  <= stage_out;
			o2_q <= stage_out;
		end
		if (state_q == ST_FINAL && out_free) begin
			out_data_q <= mv_sat;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// no transaction is taken while a shared unit still works
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!mul_busy && !div_busy))
		else $error("input ready while a shared unit is busy");

	// one transaction at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second transaction taken during an update");

	// multiplier never restarted mid-operation
	a_mul_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_cmd.start |-> !mul_busy)
		else $error("multiplier started while busy");

	// derivative product uses a finished quotient
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KD) |-> !div_busy)
		else $error("derivative used before divide finished");
`endif

endmodule
`default_nettype wire

### sv/cpid_mul_unit.sv
// shared multiply-accumulate unit, 16-bit digits of the value per cycle
`default_nettype none
module cpid_mul_unit (
	input  wire                       clk,
	input  wire                       arst_n,
	input  cpid_pkg::mul_cmd_t        cmd,
	output logic                      busy,
	output logic                      done,
	output logic [cpid_pkg::ACC_W-1:0] acc
);
	import cpid_pkg::*;

	logic                busy_q, done_q;
	logic [2:0]          cnt_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [INTEG_W-1:0]  mag_q;
	logic                neg_q;
	logic [63:0]         pp_q;
	logic [ACC_W-1:0]    acc_q;
	logic [15:0]         digit;
	logic [63:0]         pp_c;
	logic [1:0]          idx;
	logic [ACC_W-1:0]    term;

	assign digit = mag_q[{cnt_q[1:0], 4'b0} +: 16];
	assign pp_c  = {16'b0, gain_q} * {48'b0, digit};
	assign idx   = cnt_q[1:0] - 2'd1;
	assign term  = {64'b0, pp_q} << {idx, 4'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			gain_q <= cmd.gain;
			neg_q  <= cmd.val[INTEG_W-1];
			mag_q  <= cmd.val[INTEG_W-1] ? (~cmd.val + 64'd1) : cmd.val;
			if (cmd.clr) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_q <= pp_c;
			end
			if (cnt_q != 3'd0) begin
				acc_q <= neg_q ? (acc_q - term) : (acc_q + term);
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign acc  = acc_q;

endmodule
`default_nettype wire

### sv/cpid_div_unit.sv
// restoring serial divider, one quotient bit per cycle
`default_nettype none
module cpid_div_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  cpid_pkg::div_cmd_t               cmd,
	output logic                             busy,
	output logic signed [cpid_pkg::QUO_W-1:0] quotient
);
	import cpid_pkg::*;

	logic             busy_q;
	logic [5:0]       cnt_q;
	logic             neg_q;
	logic [DT_W-1:0]  dvs_q;
	logic [DT_W-1:0]  rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [DT_W:0]    trial;
	logic             fits;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(QUO_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			neg_q <= cmd.dividend[QUO_W-1];
			quo_q <= cmd.dividend[QUO_W-1] ? (~cmd.dividend + 49'd1) : cmd.dividend;
			dvs_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DT_W'(trial - {1'b0, dvs_q}) : trial[DT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? (~quo_q + 49'd1) : quo_q;

endmodule
`default_nettype wire

### tb/cascaded_pid_axis_controller_unit_tb.sv
// testbench of the cascaded pid axis controller: predicts each move and checks it
`timescale 1ns / 100ps
`default_nettype none
module cascaded_pid_axis_controller_unit_tb;
	import cpid_pkg::*;

	localparam int  GAIN_FRAC  = 46;
	localparam int  VALUE_FRAC = 16;
	localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint S48_MIN = -S48_MAX - 1;
	localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint S64_MIN = -S64_MAX - 1;
	localparam logic [47:0] GAIN_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int  DRAIN_CYCLES = 300;

	// scoreboard: own copy of gains and stage state, queue of pending moves
	class pid_move_scoreboard;
		logic [47:0] kp, ki, kd;
		bit          flip_error;
		longint      integ_a, prev_a, integ_b, prev_b;
		logic [31:0] expected_moves[$];
		int          errors;

		function new();
			kp = KP_RESET;
			ki = KI_RESET;
			kd = KD_RESET;
			flip_error = 0;
			integ_a = 0; prev_a = 0; integ_b = 0; prev_b = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [47:0] value);
			case (idx)
				REG_KP:   kp = value;
				REG_KI:   ki = value;
				REG_KD:   kd = value;
				REG_SIGN: flip_error = value[0];
			endcase
		endfunction

		// one pid stage: saturating integral, truncated derivative, exact sum, floor shift and 48-bit clamp
		function longint pid_stage(longint e, longint dt, inout longint integ,
				inout longint prev);
			longint p, d;
			logic signed [64:0]  acc;
			logic signed [127:0] ew, iw, dw, sum, sh;
			p = e * dt;
			acc = {integ[63], integ} + {p[63], p};
			if (acc[64] != acc[63])
				integ = acc[64] ? S64_MIN : S64_MAX;
			else
				integ = acc[63:0];
			d = (e - prev) / dt;
			ew = e;
			iw = integ;
			dw = d;
			sum = $signed({80'd0, kp}) * ew + $signed({80'd0, ki}) * iw
				+ $signed({80'd0, kd}) * dw;
			sh = sum >>> GAIN_FRAC;
			prev = e;
			if (sh > S48_MAX) return S48_MAX;
			if (sh < S48_MIN) return S48_MIN;
			return longint'(sh);
		endfunction

		function void note_update(logic [7:0] ref_pos, logic [7:0] meas_pos,
				logic [15:0] elapsed);
			longint diff, dt, o1, o2, mv;
			diff = flip_error ? longint'(meas_pos) - longint'(ref_pos)
				: longint'(ref_pos) - longint'(meas_pos);
			dt = (elapsed == 0) ? 1 : longint'(elapsed);
			o1 = pid_stage(diff <<< VALUE_FRAC, dt, integ_a, prev_a);
			o2 = pid_stage(o1, dt, integ_b, prev_b);
			mv = o2 / (longint'(1) <<< VALUE_FRAC);
			if (mv > 64'sd2147483647) mv = 64'sd2147483647;
			if (mv < -64'sd2147483648) mv = -64'sd2147483648;
			expected_moves.push_back(mv[31:0]);
		endfunction

		function void check_move(logic [31:0] got);
			logic [31:0] want;
			if (expected_moves.size() == 0) begin
				$display("%0t: move_steps with none expected, actual %0d", $time,
					$signed(got));
				errors++;
				return;
			end
			want = expected_moves.pop_front();
			if (got !== want) begin
				$display("%0t: move_steps mismatch, expected %0d actual %0d", $time,
					$signed(want), $signed(got));
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // reference_position, measured_position, elapsed_ms
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;       // move_steps
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;

	pid_move_scoreboard sb = new();
	bit steady_flow = 0;  // when set neither side idles

	cascaded_pid_axis_controller_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// receiver stalls at random, with a probability of 9 percent
	always @(negedge clk) begin
		m_axis_tready = steady_flow || ($urandom_range(0, 99) >= 9);
	end

	// every result transaction is checked against the oldest pending move
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_move(m_axis_tdata);
	end

	// register write while the block is idle
	task automatic write_cfg(reg_idx_t idx, logic [47:0] value);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = value;
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// one input transaction; valid stays high if the next one follows at once
	task automatic send_update(logic [7:0] ref_pos, logic [7:0] meas_pos,
			logic [15:0] elapsed);
		@(negedge clk);
		while (!steady_flow && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid = 0;
			@(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata = {elapsed, meas_pos, ref_pos};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_update(ref_pos, meas_pos, elapsed);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 0;
		while (sb.expected_moves.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_elapsed();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 200));
			3: return 16'($urandom_range(90, 110));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return GAIN_MAX;
			2: return 48'($urandom_range(0, 1 << 20));
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset gains, field extremes, zero elapsed time
		send_update(8'd0, 8'd0, 16'd0);
		send_update(8'd255, 8'd0, 16'd0);
		send_update(8'd0, 8'd255, 16'd1);
		send_update(8'd255, 8'd255, 16'hFFFF);
		send_update(8'd255, 8'd0, 16'hFFFF);
		send_update(8'd0, 8'd255, 16'hFFFF);
		send_update(8'd170, 8'd85, 16'd100);
		send_update(8'd85, 8'd170, 16'hAAAA);
		send_update(8'd1, 8'd128, 16'h5555);
		drain();

		// directed: all gains at maximum, flipped error; saturates stages and integrals
		write_cfg(REG_KP, GAIN_MAX);
		write_cfg(REG_KI, GAIN_MAX);
		write_cfg(REG_KD, GAIN_MAX);
		write_cfg(REG_SIGN, 48'hFFFF_FFFF_FFFF);
		for (int i = 0; i < 6; i++)
			send_update(8'd255, 8'd0, 16'hFFFF);
		for (int i = 0; i < 6; i++)
			send_update(8'd0, 8'd255, (i % 2) ? 16'hFFFF : 16'd0);
		drain();

		// random phases with changing gains; one phase runs without any idling
		for (int ph = 0; ph < 7; ph++) begin
			write_cfg(REG_KP, (ph == 0) ? '0 : pick_gain());
			write_cfg(REG_KI, (ph == 0) ? '0 : pick_gain());
			write_cfg(REG_KD, (ph == 0) ? '0 : pick_gain());
			write_cfg(REG_SIGN, 48'({$urandom, $urandom}));
			steady_flow = (ph == 3);
			for (int i = 0; i < 200; i++)
				send_update(8'($urandom), 8'($urandom), pick_elapsed());
			drain();
			steady_flow = 0;
		end

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
sv/cpid_pkg.sv
sv/cpid_mul_unit.sv
sv/cpid_div_unit.sv
sv/cascaded_pid_axis_controller_unit.sv
tb/cascaded_pid_axis_controller_unit_tb.sv
